FILE: rtl/roc_pkg.sv
// ----------------------------------------------------------------------------
// roc_pkg: shared types and constants for the refcounted object cache
// Holds opcodes, status and action codes, and the command beat type passed
// from the front end to the back end.
// ----------------------------------------------------------------------------
package roc_pkg;

  localparam int unsigned SetsDef   = 16;
  localparam int unsigned WaysDef   = 8;
  localparam int unsigned RefBitsDef = 16;
  localparam int unsigned MaxOut    = 8;

  localparam logic [2:0] OP_RETRIEVE = 3'd0;
  localparam logic [2:0] OP_GRAB     = 3'd1;
  localparam logic [2:0] OP_DISCARD  = 3'd2;
  localparam logic [2:0] OP_DIRTY    = 3'd3;
  localparam logic [2:0] OP_CHECK    = 3'd4;
  localparam logic [2:0] OP_SYNC     = 3'd5;

  localparam logic [2:0] ST_HIT_ACTIVE = 3'd0;
  localparam logic [2:0] ST_HIT_REL    = 3'd1;
  localparam logic [2:0] ST_LOADED     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_NO_FREE    = 3'd4;
  localparam logic [2:0] ST_OK         = 3'd5;
  localparam logic [2:0] ST_UNKNOWN    = 3'd6;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_WB     = 2'd2;
  localparam logic [1:0] ACT_DELETE = 2'd3;

  // command beat queued between front and back end
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] object_id;
    logic        on_disk;
    logic        object_dead;
    logic        neg;
    logic        op_bad;
  } cmd_t;

endpackage

FILE: rtl/roc_front.sv
// ----------------------------------------------------------------------------
// roc_front: command intake and classification
// Accepts start beats, flags negative ids and unused opcodes, and pushes the
// command into a two-entry queue read by the back end.
// ----------------------------------------------------------------------------
module roc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_opcode,
  input  logic signed [31:0]  in_object_id,
  input  logic                in_on_disk,
  input  logic                in_object_dead,
  output logic                q_valid,
  output roc_pkg::cmd_t       q_cmd,
  input  logic                q_pop
);
  import roc_pkg::*;

  cmd_t       slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push;
  cmd_t       cls;

  // classify incoming command
  always_comb begin
    cls.opcode      = in_opcode;
    cls.object_id   = in_object_id;
    cls.on_disk     = in_on_disk;
    cls.object_dead = in_object_dead;
    cls.neg         = in_object_id[31];
    cls.op_bad      = (in_opcode > OP_SYNC);
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = slot_r[rd_r];

  // advance queue pointers
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= cls;
    end
  end

endmodule

FILE: rtl/roc_back.sv
// ----------------------------------------------------------------------------
// roc_back: set lookup and update engine
// Reads one set into a working copy, compares its ways, emits result beats
// and writes the updated set back.
// ----------------------------------------------------------------------------
module roc_back #(
  parameter int unsigned SETS     = roc_pkg::SetsDef,
  parameter int unsigned WAYS     = roc_pkg::WaysDef,
  parameter int unsigned REF_BITS = roc_pkg::RefBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  roc_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [2:0]         out_slot,
  output logic [1:0]         out_action,
  output logic signed [31:0] out_action_object,
  output logic               out_present,
  output logic               out_last
);
  import roc_pkg::*;

  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RW = WW;
  localparam logic [REF_BITS-1:0] RefMax = '1;

  typedef struct packed {
    logic                valid;
    logic                active;
    logic                dirty;
    logic [REF_BITS-1:0] refs;
    logic [RW-1:0]       rrank;
    logic [RW-1:0]       drank;
  } meta_t;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_VICT, S_SYNC, S_WRITE} state_t;

  // one row per set; tags have undefined reset; meta clears through valid bits per set
  logic [WAYS-1:0][31:0] tag_mem [SETS];
  meta_t [WAYS-1:0]      meta_mem [SETS];
  logic [SETS-1:0] init_r;

  state_t      state_r;
  cmd_t        cmd_r;
  logic [SW-1:0] set_r;
  meta_t       m_r [WAYS];
  logic [31:0] t_r [WAYS];
  logic [3:0]  nout_r;
  logic [WW-1:0] vic_r;

  meta_t       m_nxt [WAYS];
  logic [31:0] t_nxt [WAYS];
  logic [WAYS-1:0][31:0] t_row;
  meta_t [WAYS-1:0]      m_row;
  logic        hit;
  logic [WW-1:0] hw;
  logic        vfound, dfound;
  logic [WW-1:0] vw, dw;
  logic        ov;
  logic [2:0]  ost;
  logic [2:0]  oslot;
  logic [1:0]  oact;
  logic [31:0] oobj;
  logic        opres, olast;
  state_t      state_nxt;
  logic [3:0]  nout_nxt;
  logic [WW-1:0] vic_nxt;
  logic [RW-1:0] ncnt;

  function automatic logic [2:0] way3(input logic [WW-1:0] w);
    return 3'(w);
  endfunction

  // compare ways, pick victim and newest dirty
  always_comb begin
    hit = 1'b0; hw = '0; vfound = 1'b0; vw = '0; dfound = 1'b0; dw = '0;
    for (int v = 0; v < WAYS; v++) begin
      if (!hit && m_r[v].valid && t_r[v] == cmd_r.object_id) begin
        hit = 1'b1; hw = WW'(v);
      end
      if (!m_r[v].active && (!vfound || m_r[v].rrank > m_r[vw].rrank)) begin
        vfound = 1'b1; vw = WW'(v);
      end
      if (m_r[v].dirty && (!dfound || m_r[v].drank < m_r[dw].drank)) begin
        dfound = 1'b1; dw = WW'(v);
      end
    end
  end

  // execute one step of the command on the working copy
  always_comb begin
    for (int v = 0; v < WAYS; v++) begin
      m_nxt[v] = m_r[v];
      t_nxt[v] = t_r[v];
    end
    ov = 1'b0; ost = ST_OK; oslot = 3'd0; oact = ACT_NONE; oobj = '0;
    opres = 1'b0; olast = 1'b1;
    state_nxt = state_r; nout_nxt = nout_r; vic_nxt = vic_r; ncnt = '0;
    q_pop = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
        nout_nxt = '0;
      end
      S_EXEC: begin
        ov = 1'b1;
        state_nxt = S_WRITE;
        if (cmd_r.op_bad) begin
          ost = ST_UNKNOWN;
        end else begin
          unique case (cmd_r.opcode)
            OP_RETRIEVE: begin
              if (cmd_r.neg) begin
                ost = ST_NOT_FOUND;
              end else if (hit) begin
                oslot = way3(hw);
                if (m_r[hw].active) begin
                  ost = ST_HIT_ACTIVE;
                  if (m_r[hw].refs != RefMax) m_nxt[hw].refs = m_r[hw].refs + 1'b1;
                end else begin
                  ost = ST_HIT_REL;
                  for (int v = 0; v < WAYS; v++)
                    if (v != hw && !m_r[v].active && m_r[v].rrank > m_r[hw].rrank)
                      m_nxt[v].rrank = m_r[v].rrank - 1'b1;
                  m_nxt[hw].active = 1'b1;
                  m_nxt[hw].refs = REF_BITS'(1);
                end
              end else if (!vfound) begin
                ost = ST_NO_FREE;
              end else if (m_r[vw].valid && m_r[vw].dirty) begin
                // write back victim first, then finish in S_VICT
                ost = ST_OK; oslot = way3(vw); oact = ACT_WB; oobj = t_r[vw];
                olast = 1'b0;
                for (int v = 0; v < WAYS; v++)
                  if (v != vw && m_r[v].dirty && m_r[v].drank > m_r[vw].drank)
                    m_nxt[v].drank = m_r[v].drank - 1'b1;
                m_nxt[vw].dirty = 1'b0; m_nxt[vw].drank = '0;
                vic_nxt = vw;
                state_nxt = S_VICT;
              end else begin
                ov = 1'b0;
                vic_nxt = vw;
                state_nxt = S_VICT;
              end
            end
            OP_GRAB, OP_DISCARD: begin
              if (cmd_r.neg || !hit || !m_r[hw].active) begin
                ost = ST_UNKNOWN;
              end else begin
                oslot = way3(hw);
                if (cmd_r.opcode == OP_GRAB) begin
                  if (m_r[hw].refs != RefMax) m_nxt[hw].refs = m_r[hw].refs + 1'b1;
                end else if (m_r[hw].refs != REF_BITS'(1)) begin
                  m_nxt[hw].refs = m_r[hw].refs - 1'b1;
                end else if (cmd_r.object_dead) begin
                  m_nxt[hw].refs = '0;
                  if (m_r[hw].dirty) begin
                    for (int v = 0; v < WAYS; v++)
                      if (v != hw && m_r[v].dirty && m_r[v].drank > m_r[hw].drank)
                        m_nxt[v].drank = m_r[v].drank - 1'b1;
                  end
                  m_nxt[hw].dirty = 1'b0; m_nxt[hw].drank = '0;
                  m_nxt[hw].active = 1'b0; m_nxt[hw].valid = 1'b0;
                  t_nxt[hw] = '0;
                  for (int v = 0; v < WAYS; v++)
                    if (v != hw && !m_r[v].active) ncnt = ncnt + 1'b1;
                  m_nxt[hw].rrank = ncnt;
                  oact = ACT_DELETE; oobj = cmd_r.object_id;
                end else begin
                  m_nxt[hw].refs = '0;
                  for (int v = 0; v < WAYS; v++)
                    if (v != hw && !m_r[v].active) m_nxt[v].rrank = m_r[v].rrank + 1'b1;
                  m_nxt[hw].rrank = '0;
                  m_nxt[hw].active = 1'b0;
                end
              end
            end
            OP_DIRTY: begin
              if (cmd_r.neg || !hit) begin
                ost = ST_UNKNOWN;
              end else begin
                oslot = way3(hw);
                if (!m_r[hw].dirty) begin
                  for (int v = 0; v < WAYS; v++)
                    if (m_r[v].dirty) m_nxt[v].drank = m_r[v].drank + 1'b1;
                  m_nxt[hw].dirty = 1'b1; m_nxt[hw].drank = '0;
                end
              end
            end
            OP_CHECK: begin
              if (!cmd_r.neg && hit) begin
                oslot = way3(hw); opres = 1'b1;
              end else if (!(!cmd_r.neg && cmd_r.on_disk)) begin
                ost = ST_NOT_FOUND;
              end
            end
            OP_SYNC: begin
              ov = 1'b0;
              state_nxt = S_SYNC;
            end
            default: ost = ST_UNKNOWN;
          endcase
        end
      end
      S_VICT: begin
        // finish a miss after any write-back
        ov = 1'b1;
        state_nxt = S_WRITE;
        m_nxt[vic_r].dirty = 1'b0; m_nxt[vic_r].drank = '0;
        if (cmd_r.on_disk) begin
          for (int v = 0; v < WAYS; v++)
            if (v != vic_r && !m_r[v].active && m_r[v].rrank > m_r[vic_r].rrank)
              m_nxt[v].rrank = m_r[v].rrank - 1'b1;
          m_nxt[vic_r].valid = 1'b1; m_nxt[vic_r].active = 1'b1;
          m_nxt[vic_r].refs = REF_BITS'(1);
          t_nxt[vic_r] = cmd_r.object_id;
          ost = ST_LOADED; oslot = way3(vic_r); oact = ACT_LOAD; oobj = cmd_r.object_id;
        end else begin
          m_nxt[vic_r].valid = 1'b0; t_nxt[vic_r] = '0;
          ost = ST_NOT_FOUND;
        end
      end
      S_SYNC: begin
        // write back one dirty way per cycle, newest dirtied first
        ov = 1'b1;
        if (dfound) begin
          ost = ST_OK; oslot = way3(dw); oact = ACT_WB; oobj = t_r[dw];
          for (int v = 0; v < WAYS; v++)
            if (v != dw && m_r[v].dirty && m_r[v].drank > m_r[dw].drank)
              m_nxt[v].drank = m_r[v].drank - 1'b1;
          m_nxt[dw].dirty = 1'b0; m_nxt[dw].drank = '0;
          nout_nxt = nout_r + 1'b1;
          olast = 1'b0;
          if (nout_r == 4'(MaxOut - 1)) begin
            olast = 1'b1; state_nxt = S_WRITE;
          end else begin
            // peek whether another dirty way remains
            olast = 1'b1;
            for (int v = 0; v < WAYS; v++)
              if (v != dw && m_r[v].dirty) olast = 1'b0;
            if (olast) state_nxt = S_WRITE;
          end
        end else begin
          ov = (nout_r == '0);
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // pack the working copy into one set row
  always_comb begin
    for (int v = 0; v < WAYS; v++) begin
      t_row[v] = t_r[v];
      m_row[v] = m_r[v];
    end
  end

  // hold state, working copy and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      init_r    <= '0;
      nout_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ov;
      nout_r    <= nout_nxt;
      if (state_r == S_WRITE) init_r[set_r] <= 1'b1;
    end
    vic_r             <= vic_nxt;
    out_status        <= ost;
    out_slot          <= oslot;
    out_action        <= oact;
    out_action_object <= oobj;
    out_present       <= opres;
    out_last          <= olast;
    if (q_pop) begin
      cmd_r <= q_cmd;
      set_r <= SW'(q_cmd.object_id % SETS);
    end
    if (state_r == S_READ) begin
      for (int v = 0; v < WAYS; v++) begin
        t_r[v] <= tag_mem[set_r][v];
        if (init_r[set_r]) begin
          m_r[v] <= meta_mem[set_r][v];
        end else begin
          m_r[v] <= '{valid: 1'b0, active: 1'b0, dirty: 1'b0, refs: '0,
                      rrank: RW'(WAYS - 1 - v), drank: '0};
        end
      end
    end else if (state_r == S_EXEC || state_r == S_VICT || state_r == S_SYNC) begin
      for (int v = 0; v < WAYS; v++) begin
        m_r[v] <= m_nxt[v];
        t_r[v] <= t_nxt[v];
      end
    end
  end

  // write set back
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      tag_mem[set_r]  <= t_row;
      meta_mem[set_r] <= m_row;
    end
  end

endmodule

FILE: rtl/refcounted_object_cache_top.sv
// ----------------------------------------------------------------------------
// refcounted_object_cache_top: set-associative object cache with ref counts
// Front end takes commands into a small queue; back end works on one set.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  input   | in_opcode, in_object_id, in_on_disk,    | start && !busy
//          | in_object_dead                          |
//  result  | out_status .. out_last                  | out_valid, one cycle
//
// An item steps through pop, set read, execute and write back; a miss adds a
// victim step after any write-back of a dirty victim, and sync adds a step per
// write-back. The back end pops the next command only after the write back.
// Reset marks every set as fresh; a set reads as empty until first written.
// The result side cannot stall; the input queue holds two commands.
module refcounted_object_cache_top #(
  parameter int unsigned SETS     = roc_pkg::SetsDef,
  parameter int unsigned WAYS     = roc_pkg::WaysDef,
  parameter int unsigned REF_BITS = roc_pkg::RefBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_object_id,
  input  logic               in_on_disk,
  input  logic               in_object_dead,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [2:0]         out_slot,
  output logic [1:0]         out_action,
  output logic signed [31:0] out_action_object,
  output logic               out_present,
  output logic               out_last
);
  import roc_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  roc_front u_front (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_object_id, .in_on_disk,
    .in_object_dead, .q_valid, .q_cmd, .q_pop
  );

  roc_back #(.SETS(SETS), .WAYS(WAYS), .REF_BITS(REF_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_status, .out_slot,
    .out_action, .out_action_object, .out_present, .out_last
  );

`ifndef SYNTHESIS
  // a load always names a nonnegative object
  a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_LOAD |-> !out_action_object[31])
    else $error("load of negative object");
  // a present check reports ok
  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_present |-> out_status == ST_OK && out_last)
    else $error("present without ok");
  // no pop from an empty queue
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop on empty queue");
`endif

endmodule
